FILE: rtl/wrr_pkg.sv
// Shared types and constants for the reorder window with slot acknowledge.
package wrr_pkg;

    localparam int SLOTS       = 4;
    localparam int SLOT_W      = 2;
    localparam int ALIGN_W     = 12;
    localparam int ACK_W       = 6;
    localparam int RUN_W       = 3;
    localparam int MAX_RUN     = 4;
    localparam int STEP_W      = 2;

    localparam logic [31:0] DONE_TYPE = 32'd3;
    localparam logic [31:0] CAP_RESET = 32'h0080_0000;

    localparam logic CFG_CAPACITY = 1'b0;
    localparam logic CFG_DISCARD  = 1'b1;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_BAD_TYPE  = 3'd1,
        STAT_BAD_SLOT  = 3'd2,
        STAT_TOO_LONG  = 3'd3,
        STAT_UNALIGNED = 3'd4,
        STAT_VALID_GT  = 3'd5,
        STAT_BUSY      = 3'd6,
        STAT_HALTED    = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SEARCH,
        S_RETIRE
    } t_state;

    typedef enum logic [1:0] {
        STEP_VALID   = 2'd0,
        STEP_ALIGNED = 2'd1,
        STEP_COUNT   = 2'd2,
        STEP_EXPECT  = 2'd3
    } t_step;

endpackage

FILE: rtl/window_reorder_retire_ack.sv
// Top level of the reorder window: check, park and in-order retirement of completions.
//
// Usage:
// - Command channel: drive the message fields with start high; the message is taken at
//   the edge where start is high and busy is low. busy stays high until all retirements
//   caused by the message have been emitted.
// - Result channel: each result beat appears for one cycle with o_result_strobe high.
//   The receiver cannot stall; it must take every beat as it comes.
// - Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_index (0 capacity,
//   1 discard mode) in the same edge. Write only while busy is low.
// - Sequencing: a rejected or halted message gives its single status beat from the check
//   state. A parked message is searched and retired one slot at a time; each retirement
//   walks one 64-bit adder over valid total, aligned offset, chunk count and expected
//   sequence in four steps, and one message retires at most four slots.
// - The last beat of a message carries o_end_of_run. A message that only parks gives no
//   beat. A check failure or retirement of the final chunk halts the block; afterwards
//   every message answers with a halted status beat.
// - Reset (synchronous, active low) empties all slots, clears sums and the halt flag and
//   loads the default capacity of 8 MiB with discard mode off.
module window_reorder_retire_ack (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_message_type,
    input  logic [7:0]  i_slot_number,
    input  logic [63:0] i_chunk_sequence,
    input  logic [31:0] i_valid_bytes,
    input  logic [31:0] i_aligned_bytes,
    input  logic        i_final_chunk,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_wdata,
    output logic        o_result_strobe,
    output logic [2:0]  o_status,
    output logic [wrr_pkg::ACK_W-1:0] o_ack_slot,
    output logic        o_write_enable,
    output logic [63:0] o_write_offset,
    output logic [31:0] o_write_length,
    output logic [63:0] o_valid_total,
    output logic [63:0] o_chunk_total,
    output logic        o_stream_done,
    output logic        o_end_of_run
);
    import wrr_pkg::*;

    t_state r_state, n_state;
    logic   r_halted, n_halted;
    logic [31:0] r_capacity;
    logic        r_discard;

    logic [31:0] r_in_type;
    logic [7:0]  r_in_slot;
    logic [63:0] r_in_seq;
    logic [31:0] r_in_vlen, r_in_alen;
    logic        r_in_fin;

    logic [SLOTS-1:0] r_slot_busy, n_slot_busy;
    logic [63:0] r_slot_seq  [SLOTS];
    logic [31:0] r_slot_vlen [SLOTS];
    logic [31:0] r_slot_alen [SLOTS];
    logic        r_slot_fin  [SLOTS];
    logic        park;

    logic [63:0] r_expected, n_expected;
    logic [63:0] r_valid_sum, n_valid_sum;
    logic [63:0] r_aligned_sum, n_aligned_sum;
    logic [63:0] r_chunk_count, n_chunk_count;

    logic [RUN_W-1:0]  r_n, n_n;
    logic [STEP_W-1:0] r_step, n_step;
    logic [SLOT_W-1:0] r_cur, n_cur;

    logic        r_pend, n_pend;
    logic [SLOT_W-1:0] r_p_slot, n_p_slot;
    logic        r_p_wen, n_p_wen;
    logic [63:0] r_p_woff, n_p_woff;
    logic [31:0] r_p_wlen, n_p_wlen;
    logic [63:0] r_p_vtot, n_p_vtot;
    logic [63:0] r_p_ctot, n_p_ctot;
    logic        r_p_done, n_p_done;

    logic        r_out_strobe, n_out_strobe;
    t_status     r_out_status, n_out_status;
    logic [ACK_W-1:0] r_out_ack, n_out_ack;
    logic        r_out_wen, n_out_wen;
    logic [63:0] r_out_woff, n_out_woff;
    logic [31:0] r_out_wlen, n_out_wlen;
    logic [63:0] r_out_vtot, n_out_vtot;
    logic [63:0] r_out_ctot, n_out_ctot;
    logic        r_out_done, n_out_done;
    logic        r_out_eor, n_out_eor;

    t_status     chk_status;
    logic        found;
    logic [SLOT_W-1:0] found_idx;
    logic        last_beat;
    logic        cur_nz;
    logic [63:0] add_a, add_b, add_sum;

    // message checks in priority order
    always_comb begin
        if (r_in_type != DONE_TYPE) begin
            chk_status = STAT_BAD_TYPE;
        end else if (r_in_slot[7:SLOT_W] != '0) begin
            chk_status = STAT_BAD_SLOT;
        end else if (r_in_vlen > r_capacity || r_in_alen > r_capacity) begin
            chk_status = STAT_TOO_LONG;
        end else if (r_in_alen[ALIGN_W-1:0] != '0) begin
            chk_status = STAT_UNALIGNED;
        end else if (r_in_vlen > r_in_alen) begin
            chk_status = STAT_VALID_GT;
        end else if (r_slot_busy[r_in_slot[SLOT_W-1:0]]) begin
            chk_status = STAT_BUSY;
        end else begin
            chk_status = STAT_OK;
        end
    end

    // lowest parked slot holding the expected sequence
    always_comb begin
        found     = 1'b0;
        found_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_slot_busy[i] && r_slot_seq[i] == r_expected) begin
                found     = 1'b1;
                found_idx = SLOT_W'(i);
            end
        end
    end

    assign last_beat = r_pend && (r_p_done || r_n == RUN_W'(MAX_RUN) || !found);
    assign cur_nz    = r_slot_vlen[r_cur] != '0;

    // shared 64-bit adder, one operand pair per retirement step
    always_comb begin
        add_a = r_expected;
        add_b = 64'd1;
        case (t_step'(r_step))
            STEP_VALID: begin
                add_a = r_valid_sum;
                add_b = cur_nz ? {32'd0, r_slot_vlen[r_cur]} : 64'd0;
            end
            STEP_ALIGNED: begin
                add_a = r_aligned_sum;
                add_b = cur_nz ? {32'd0, r_slot_alen[r_cur]} : 64'd0;
            end
            STEP_COUNT: begin
                add_a = r_chunk_count;
                add_b = {63'd0, cur_nz};
            end
            STEP_EXPECT: begin
                add_a = r_expected;
                add_b = 64'd1;
            end
            default: begin
                add_a = r_expected;
                add_b = 64'd1;
            end
        endcase
    end

    assign add_sum = add_a + add_b;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_halted || chk_status != STAT_OK) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (last_beat || !found) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_RETIRE;
                end
            end
            S_RETIRE: begin
                if (t_step'(r_step) == STEP_EXPECT) begin
                    n_state = S_SEARCH;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_halted      = r_halted;
        n_slot_busy   = r_slot_busy;
        park          = 1'b0;
        n_expected    = r_expected;
        n_valid_sum   = r_valid_sum;
        n_aligned_sum = r_aligned_sum;
        n_chunk_count = r_chunk_count;
        n_n           = r_n;
        n_step        = r_step;
        n_cur         = r_cur;
        n_pend        = r_pend;
        n_p_slot      = r_p_slot;
        n_p_wen       = r_p_wen;
        n_p_woff      = r_p_woff;
        n_p_wlen      = r_p_wlen;
        n_p_vtot      = r_p_vtot;
        n_p_ctot      = r_p_ctot;
        n_p_done      = r_p_done;
        n_out_strobe  = 1'b0;
        n_out_status  = r_out_status;
        n_out_ack     = r_out_ack;
        n_out_wen     = r_out_wen;
        n_out_woff    = r_out_woff;
        n_out_wlen    = r_out_wlen;
        n_out_vtot    = r_out_vtot;
        n_out_ctot    = r_out_ctot;
        n_out_done    = r_out_done;
        n_out_eor     = r_out_eor;
        case (r_state)
            S_IDLE: begin
            end
            S_CHECK: begin
                if (r_halted || chk_status != STAT_OK) begin
                    n_out_strobe = 1'b1;
                    n_out_status = r_halted ? STAT_HALTED : chk_status;
                    n_out_ack    = '0;
                    n_out_wen    = 1'b0;
                    n_out_woff   = '0;
                    n_out_wlen   = '0;
                    n_out_vtot   = '0;
                    n_out_ctot   = '0;
                    n_out_done   = 1'b0;
                    n_out_eor    = 1'b1;
                    n_halted     = 1'b1;
                end else begin
                    park = 1'b1;
                    n_slot_busy[r_in_slot[SLOT_W-1:0]] = 1'b1;
                    n_n    = '0;
                    n_pend = 1'b0;
                end
            end
            S_SEARCH: begin
                if (r_pend && (last_beat || found)) begin
                    n_out_strobe = 1'b1;
                    n_out_status = STAT_OK;
                    n_out_ack    = {{(ACK_W-SLOT_W){1'b0}}, r_p_slot};
                    n_out_wen    = r_p_wen;
                    n_out_woff   = r_p_woff;
                    n_out_wlen   = r_p_wlen;
                    n_out_vtot   = r_p_vtot;
                    n_out_ctot   = r_p_ctot;
                    n_out_done   = r_p_done;
                    n_out_eor    = last_beat;
                    n_pend       = 1'b0;
                    if (last_beat && r_p_done) begin
                        n_halted = 1'b1;
                    end
                end
                if (!last_beat && found) begin
                    n_cur  = found_idx;
                    n_step = STEP_W'(STEP_VALID);
                end
            end
            S_RETIRE: begin
                n_step = r_step + STEP_W'(1);
                case (t_step'(r_step))
                    STEP_VALID: begin
                        n_valid_sum = add_sum;
                        n_p_vtot    = add_sum;
                    end
                    STEP_ALIGNED: begin
                        n_aligned_sum = add_sum;
                        n_p_woff      = (cur_nz && !r_discard) ? r_aligned_sum : 64'd0;
                    end
                    STEP_COUNT: begin
                        n_chunk_count = add_sum;
                        n_p_ctot      = add_sum;
                    end
                    STEP_EXPECT: begin
                        n_expected         = add_sum;
                        n_slot_busy[r_cur] = 1'b0;
                        n_pend             = 1'b1;
                        n_p_slot           = r_cur;
                        n_p_wen            = cur_nz && !r_discard;
                        n_p_wlen           = (cur_nz && !r_discard) ? r_slot_alen[r_cur] : 32'd0;
                        n_p_done           = r_slot_fin[r_cur];
                        n_n                = r_n + RUN_W'(1);
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_halted      <= 1'b0;
            r_capacity    <= CAP_RESET;
            r_discard     <= 1'b0;
            r_slot_busy   <= '0;
            r_expected    <= '0;
            r_valid_sum   <= '0;
            r_aligned_sum <= '0;
            r_chunk_count <= '0;
            r_n           <= '0;
            r_step        <= '0;
            r_pend        <= 1'b0;
            r_out_strobe  <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_halted      <= n_halted;
            r_slot_busy   <= n_slot_busy;
            r_expected    <= n_expected;
            r_valid_sum   <= n_valid_sum;
            r_aligned_sum <= n_aligned_sum;
            r_chunk_count <= n_chunk_count;
            r_n           <= n_n;
            r_step        <= n_step;
            r_pend        <= n_pend;
            r_out_strobe  <= n_out_strobe;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_CAPACITY) begin
                    r_capacity <= i_cfg_wdata;
                end else begin
                    r_discard <= i_cfg_wdata[0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_in_type <= i_message_type;
            r_in_slot <= i_slot_number;
            r_in_seq  <= i_chunk_sequence;
            r_in_vlen <= i_valid_bytes;
            r_in_alen <= i_aligned_bytes;
            r_in_fin  <= i_final_chunk;
        end
        if (park) begin
            r_slot_seq[r_in_slot[SLOT_W-1:0]]  <= r_in_seq;
            r_slot_vlen[r_in_slot[SLOT_W-1:0]] <= r_in_vlen;
            r_slot_alen[r_in_slot[SLOT_W-1:0]] <= r_in_alen;
            r_slot_fin[r_in_slot[SLOT_W-1:0]]  <= r_in_fin;
        end
        r_cur        <= n_cur;
        r_p_slot     <= n_p_slot;
        r_p_wen      <= n_p_wen;
        r_p_woff     <= n_p_woff;
        r_p_wlen     <= n_p_wlen;
        r_p_vtot     <= n_p_vtot;
        r_p_ctot     <= n_p_ctot;
        r_p_done     <= n_p_done;
        r_out_status <= n_out_status;
        r_out_ack    <= n_out_ack;
        r_out_wen    <= n_out_wen;
        r_out_woff   <= n_out_woff;
        r_out_wlen   <= n_out_wlen;
        r_out_vtot   <= n_out_vtot;
        r_out_ctot   <= n_out_ctot;
        r_out_done   <= n_out_done;
        r_out_eor    <= n_out_eor;
    end

    assign busy            = r_state != S_IDLE;
    assign o_result_strobe = r_out_strobe;
    assign o_status        = r_out_status;
    assign o_ack_slot      = r_out_ack;
    assign o_write_enable  = r_out_wen;
    assign o_write_offset  = r_out_woff;
    assign o_write_length  = r_out_wlen;
    assign o_valid_total   = r_out_vtot;
    assign o_chunk_total   = r_out_ctot;
    assign o_stream_done   = r_out_done;
    assign o_end_of_run    = r_out_eor;

endmodule

FILE: rtl/wrr_checker.sv
// Port-level checker for the reorder window, bound to the top level.
module wrr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_result_strobe,
    input logic [2:0]  o_status,
    input logic [wrr_pkg::ACK_W-1:0] o_ack_slot,
    input logic        o_write_enable,
    input logic [63:0] o_write_offset,
    input logic [31:0] o_write_length,
    input logic [63:0] o_valid_total,
    input logic        o_end_of_run
);
    import wrr_pkg::*;

    a_error_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe && o_status != STAT_OK |-> o_end_of_run)
        else $error("error status beat without end of run");

    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe && !o_write_enable |-> o_write_offset == '0 && o_write_length == '0)
        else $error("suppressed write carries offset or length");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe && o_status != STAT_OK |-> o_ack_slot == '0 && o_valid_total == '0)
        else $error("status beat carries retirement fields");

endmodule

bind window_reorder_retire_ack wrr_checker u_wrr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_result_strobe (o_result_strobe),
    .o_status        (o_status),
    .o_ack_slot      (o_ack_slot),
    .o_write_enable  (o_write_enable),
    .o_write_offset  (o_write_offset),
    .o_write_length  (o_write_length),
    .o_valid_total   (o_valid_total),
    .o_end_of_run    (o_end_of_run)
);

FILE: dv/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the reorder window: in-order slot retirement, acks and write commands.
module tb;
    import wrr_pkg::*;

    localparam logic [31:0] BLOCK_BYTES   = 32'd1 << ALIGN_W;
    localparam int          SETTLE_CYCLES = 30;
    localparam int          PHASE_ITEMS   = 25;
    localparam int          PHASES        = 8;
    localparam int          PRINT_CAP     = 40;

    typedef struct packed {
        logic [31:0] mtype;
        logic [7:0]  slot;
        logic [63:0] seq;
        logic [31:0] vlen;
        logic [31:0] alen;
        logic        fin;
    } completion_t;

    typedef struct packed {
        t_status          status;
        logic [ACK_W-1:0] ack;
        logic             wen;
        logic [63:0]      woff;
        logic [31:0]      wlen;
        logic [63:0]      vtot;
        logic [63:0]      ctot;
        logic             done;
        logic             eor;
    } ack_beat_t;

    typedef struct packed {
        completion_t msg;
        logic        typed;
        ack_beat_t   want;
    } script_row_t;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [31:0]      i_message_type;
    logic [7:0]       i_slot_number;
    logic [63:0]      i_chunk_sequence;
    logic [31:0]      i_valid_bytes;
    logic [31:0]      i_aligned_bytes;
    logic             i_final_chunk;
    logic             i_cfg_we;
    logic             i_cfg_index;
    logic [31:0]      i_cfg_wdata;
    logic             o_result_strobe;
    logic [2:0]       o_status;
    logic [ACK_W-1:0] o_ack_slot;
    logic             o_write_enable;
    logic [63:0]      o_write_offset;
    logic [31:0]      o_write_length;
    logic [63:0]      o_valid_total;
    logic [63:0]      o_chunk_total;
    logic             o_stream_done;
    logic             o_end_of_run;

    logic        park_busy [SLOTS];
    logic [63:0] park_seq  [SLOTS];
    logic [31:0] park_vlen [SLOTS];
    logic [31:0] park_alen [SLOTS];
    logic        park_fin  [SLOTS];
    logic [63:0] next_seq;
    logic [63:0] sum_valid;
    logic [63:0] sum_aligned;
    logic [63:0] n_chunks;
    logic        stopped;
    logic [31:0] cap_reg;
    logic        discard_reg;

    ack_beat_t   due_acks [$];
    ack_beat_t   fresh    [$];
    script_row_t opening  [$];
    int          mismatches = 0;
    bit          eager = 1'b0;

    window_reorder_retire_ack dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_message_type   (i_message_type),
        .i_slot_number    (i_slot_number),
        .i_chunk_sequence (i_chunk_sequence),
        .i_valid_bytes    (i_valid_bytes),
        .i_aligned_bytes  (i_aligned_bytes),
        .i_final_chunk    (i_final_chunk),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_result_strobe  (o_result_strobe),
        .o_status         (o_status),
        .o_ack_slot       (o_ack_slot),
        .o_write_enable   (o_write_enable),
        .o_write_offset   (o_write_offset),
        .o_write_length   (o_write_length),
        .o_valid_total    (o_valid_total),
        .o_chunk_total    (o_chunk_total),
        .o_stream_done    (o_stream_done),
        .o_end_of_run     (o_end_of_run)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        if (mismatches < PRINT_CAP) $display("%0t: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) flag_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
    endtask

    function automatic ack_beat_t status_beat(input t_status s);
        ack_beat_t b;
        b = '0;
        b.status = s;
        b.eor = 1'b1;
        return b;
    endfunction

    function automatic void retire_in_order(input completion_t c);
        t_status           code;
        ack_beat_t         b;
        int                hit;
        logic [SLOT_W-1:0] s;
        fresh.delete();
        if (stopped) begin
            fresh.push_back(status_beat(STAT_HALTED));
            return;
        end
        code = STAT_OK;
        if (c.mtype != DONE_TYPE) code = STAT_BAD_TYPE;
        else if (c.slot >= SLOTS) code = STAT_BAD_SLOT;
        else if (c.vlen > cap_reg || c.alen > cap_reg) code = STAT_TOO_LONG;
        else if (c.alen[ALIGN_W-1:0] != '0) code = STAT_UNALIGNED;
        else if (c.vlen > c.alen) code = STAT_VALID_GT;
        else if (park_busy[c.slot[SLOT_W-1:0]]) code = STAT_BUSY;
        if (code != STAT_OK) begin
            stopped = 1'b1;
            fresh.push_back(status_beat(code));
            return;
        end
        s = c.slot[SLOT_W-1:0];
        park_busy[s] = 1'b1;
        park_seq[s]  = c.seq;
        park_vlen[s] = c.vlen;
        park_alen[s] = c.alen;
        park_fin[s]  = c.fin;
        while (fresh.size() < MAX_RUN) begin
            hit = -1;
            // scan downwards so the lowest matching slot wins
            for (int i = SLOTS - 1; i >= 0; i--)
                if (park_busy[i] && park_seq[i] == next_seq) hit = i;
            if (hit < 0) break;
            b = status_beat(STAT_OK);
            b.eor = 1'b0;
            b.ack = ACK_W'(hit);
            if (park_vlen[hit] != 0) begin
                if (!discard_reg) begin
                    b.wen  = 1'b1;
                    b.woff = sum_aligned;
                    b.wlen = park_alen[hit];
                end
                sum_valid   += 64'(park_vlen[hit]);
                sum_aligned += 64'(park_alen[hit]);
                n_chunks++;
            end
            b.vtot = sum_valid;
            b.ctot = n_chunks;
            b.done = park_fin[hit];
            park_busy[hit] = 1'b0;
            park_seq[hit]  = '0;
            park_vlen[hit] = '0;
            park_alen[hit] = '0;
            park_fin[hit]  = 1'b0;
            next_seq++;
            fresh.push_back(b);
            if (b.done) begin
                stopped = 1'b1;
                break;
            end
        end
        if (fresh.size() != 0) begin
            b = fresh.pop_back();
            b.eor = 1'b1;
            fresh.push_back(b);
        end
    endfunction

    function automatic void pick_lengths(output logic [31:0] vlen, output logic [31:0] alen);
        logic [31:0] blocks;
        blocks = cap_reg / BLOCK_BYTES;
        case ($urandom_range(0, 3))
            0: begin
                alen = $urandom_range(0, blocks) * BLOCK_BYTES;
                vlen = '0;
            end
            1: begin
                alen = blocks * BLOCK_BYTES;
                vlen = alen;
            end
            default: begin
                alen = $urandom_range(0, blocks) * BLOCK_BYTES;
                vlen = $urandom_range(0, alen);
            end
        endcase
    endfunction

    task automatic issue(input completion_t c, input logic typed, input ack_beat_t want);
        if (!eager && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        start            <= 1'b1;
        i_message_type   <= c.mtype;
        i_slot_number    <= c.slot;
        i_chunk_sequence <= c.seq;
        i_valid_bytes    <= c.vlen;
        i_aligned_bytes  <= c.alen;
        i_final_chunk    <= c.fin;
        // hold the beat until the block takes it
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        retire_in_order(c);
        if (typed) due_acks.push_back(want);
        else foreach (fresh[i]) due_acks.push_back(fresh[i]);
        @(negedge i_clk);
    endtask

    task automatic settle();
        start <= 1'b0;
        while (due_acks.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic load_settings(input logic [31:0] cap, input logic disc);
        logic [31:0] junk;
        junk = $urandom;
        junk[0] = disc;
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_CAPACITY;
        i_cfg_wdata <= cap;
        @(negedge i_clk);
        i_cfg_index <= CFG_DISCARD;
        i_cfg_wdata <= junk;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cap_reg = cap;
        discard_reg = disc;
    endtask

    always @(posedge i_clk) begin
        ack_beat_t want;
        if (i_rst_n && o_result_strobe !== 1'b0) begin
            if (due_acks.size() == 0) begin
                flag_mismatch("result beat with nothing due");
            end else begin
                want = due_acks.pop_front();
                check_field("status", o_status, want.status);
                check_field("ack_slot", o_ack_slot, want.ack);
                check_field("write_enable", o_write_enable, want.wen);
                check_field("write_offset", o_write_offset, want.woff);
                check_field("write_length", o_write_length, want.wlen);
                check_field("valid_total", o_valid_total, want.vtot);
                check_field("chunk_total", o_chunk_total, want.ctot);
                check_field("stream_done", o_stream_done, want.done);
                check_field("end_of_run", o_end_of_run, want.eor);
            end
        end
    end

    initial begin
        completion_t c;
        logic [31:0] phase_cap [PHASES];
        logic        phase_disc [PHASES];
        logic [63:0] base;
        int          k;
        int          j;
        int          tmp;
        int          sent;
        int          pick;
        int          slot_order [SLOTS];
        int          seq_order [SLOTS];

        i_rst_n          = 1'b0;
        start            = 1'b0;
        i_message_type   = '0;
        i_slot_number    = '0;
        i_chunk_sequence = '0;
        i_valid_bytes    = '0;
        i_aligned_bytes  = '0;
        i_final_chunk    = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = CFG_CAPACITY;
        i_cfg_wdata      = '0;

        for (int i = 0; i < SLOTS; i++) begin
            park_busy[i] = 1'b0;
            park_seq[i]  = '0;
            park_vlen[i] = '0;
            park_alen[i] = '0;
            park_fin[i]  = 1'b0;
        end
        next_seq    = '0;
        sum_valid   = '0;
        sum_aligned = '0;
        n_chunks    = '0;
        stopped     = 1'b0;
        cap_reg     = CAP_RESET;
        discard_reg = 1'b0;

        opening.push_back('{'{DONE_TYPE, 8'd0, 64'd0, 32'd0, 32'd0, 1'b0}, 1'b1,
            '{STAT_OK, 6'd0, 1'b0, 64'd0, 32'd0, 64'd0, 64'd0, 1'b0, 1'b1}});
        opening.push_back('{'{DONE_TYPE, 8'd3, 64'd1, 32'd1, 32'd4096, 1'b0}, 1'b1,
            '{STAT_OK, 6'd3, 1'b1, 64'd0, 32'd4096, 64'd1, 64'd1, 1'b0, 1'b1}});
        opening.push_back('{'{DONE_TYPE, 8'd1, 64'd3, 32'd4096, 32'd4096, 1'b0}, 1'b0, '0});
        opening.push_back('{'{DONE_TYPE, 8'd2, 64'd4, 32'd0, 32'd8192, 1'b0}, 1'b0, '0});
        opening.push_back('{'{DONE_TYPE, 8'd0, 64'd5, 32'h7F_FFFF, CAP_RESET, 1'b0}, 1'b0, '0});
        opening.push_back('{'{DONE_TYPE, 8'd3, 64'd2, CAP_RESET, CAP_RESET, 1'b0}, 1'b0, '0});
        opening.push_back('{'{DONE_TYPE, 8'd2, 64'd6, 32'd4095, 32'd4096, 1'b0}, 1'b0, '0});
        opening.push_back('{'{DONE_TYPE, 8'd0, 64'd8, 32'd12345, 32'd16384, 1'b0}, 1'b0, '0});
        opening.push_back('{'{DONE_TYPE, 8'd1, 64'd7, 32'd1, 32'd4096, 1'b0}, 1'b0, '0});
        opening.push_back('{'{DONE_TYPE, 8'd3, 64'd9, 32'd0, CAP_RESET, 1'b0}, 1'b0, '0});

        phase_cap  = '{32'd4096, 32'hFFFF_F000, 32'hFFFF_FFFF, CAP_RESET, 32'd0,
                       32'($urandom), 32'($urandom_range(1, 64)) * BLOCK_BYTES,
                       32'hFFFF_FFFF};
        phase_disc = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening[i]) issue(opening[i].msg, opening[i].typed, opening[i].want);

        for (int p = 0; p < PHASES; p++) begin
            settle();
            load_settings(phase_cap[p], phase_disc[p]);
            if (p == PHASES - 1) eager = 1'b1;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                k = $urandom_range(1, SLOTS);
                base = next_seq;
                for (int i = 0; i < SLOTS; i++) begin
                    slot_order[i] = i;
                    seq_order[i]  = i;
                end
                for (int i = SLOTS - 1; i > 0; i--) begin
                    j = $urandom_range(0, i);
                    tmp = slot_order[i];
                    slot_order[i] = slot_order[j];
                    slot_order[j] = tmp;
                    if (i < k) begin
                        j = $urandom_range(0, i);
                        tmp = seq_order[i];
                        seq_order[i] = seq_order[j];
                        seq_order[j] = tmp;
                    end
                end
                for (int i = 0; i < k; i++) begin
                    c.mtype = DONE_TYPE;
                    c.slot  = 8'(slot_order[i]);
                    c.seq   = base + 64'(seq_order[i]);
                    c.fin   = 1'b0;
                    pick_lengths(c.vlen, c.alen);
                    issue(c, 1'b0, '0);
                end
                sent += k;
            end
        end

        settle();
        load_settings(CAP_RESET, 1'($urandom_range(0, 1)));
        base = next_seq;
        c = '0;
        c.mtype = DONE_TYPE;
        pick_lengths(c.vlen, c.alen);
        c.slot = 8'd2;
        c.seq  = base + 64'd1;
        issue(c, 1'b0, '0);
        c.slot = 8'd1;
        issue(c, 1'b0, '0);
        c.slot = 8'd0;
        c.seq  = base;
        issue(c, 1'b0, '0);

        pick = $urandom_range(0, 6);
        c.slot = 8'd0;
        c.seq  = base + 64'd2;
        pick_lengths(c.vlen, c.alen);
        case (pick)
            0: begin
                c.slot = 8'd1;
                c.seq  = base + 64'd3;
                issue(c, 1'b0, '0);
                c.slot = 8'd0;
                c.seq  = base + 64'd2;
                c.fin  = 1'b1;
            end
            1: begin
                c.mtype = $urandom;
                if (c.mtype == DONE_TYPE) c.mtype = ~DONE_TYPE;
            end
            2: c.slot = 8'($urandom_range(SLOTS, 255));
            3: c.vlen = CAP_RESET + $urandom_range(1, 4096);
            4: begin
                c.alen = BLOCK_BYTES * $urandom_range(0, 2047)
                       + $urandom_range(1, BLOCK_BYTES - 1);
                c.vlen = '0;
            end
            5: begin
                c.alen = BLOCK_BYTES;
                c.vlen = $urandom_range(BLOCK_BYTES + 1, CAP_RESET);
            end
            default: c.slot = 8'd2;
        endcase
        issue(c, pick != 0, status_beat(t_status'(pick)));

        for (int i = 0; i < 6; i++) begin
            if (i == 0) begin
                c = '0;
            end else if (i == 1) begin
                c = '1;
            end else begin
                c.mtype = $urandom;
                c.slot  = 8'($urandom);
                c.seq   = {$urandom, $urandom};
                c.vlen  = $urandom;
                c.alen  = $urandom;
                c.fin   = 1'($urandom);
            end
            issue(c, 1'b1, status_beat(STAT_HALTED));
        end

        settle();
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
